@@ design/sgi_pkg.sv @@
`timescale 1ns / 1ps
package sgi_pkg;

    localparam int DataW   = 32;
    localparam int StepW   = 16;
    localparam int TolW    = 10;
    localparam int FillW   = 6;
    localparam int MaxFill = 63;
    localparam int DivNumW = 48;
    localparam int DivDenW = 36;
    localparam int DivCntW = 6;
    localparam int CfgIdxW = 2;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] RegStepTicks   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegGapTolerance = 2'd1;

    localparam logic [StepW-1:0] StepReset = 16'd2000;
    localparam logic [TolW-1:0]  TolReset  = 10'd100;

    // one classified item handed from the front to the back
    typedef struct packed {
        logic [DataW-1:0] cur_time;
        logic [DataW-1:0] cur_pos;
        logic [DataW-1:0] cur_vel;
        logic [DataW-1:0] prev_pos;
        logic [DataW-1:0] prev_vel;
        logic [DataW-1:0] ratio;
        logic [FillW-1:0] fill_cnt;
        logic [StepW-1:0] step;
    } t_cmd;

endpackage

@@ design/sample_gap_interpolator.sv @@
`timescale 1ns / 1ps
// An item with no gap to fill passes the front, the two-entry queue and the back's output
// register. A gap item first runs the front ratio divider, then the back runs a multiply,
// 48-step serial divide and output per filled sample, then outputs the item itself.
// The front takes no new item until it has pushed the last one; the queue lets front and
// back work at once, and the slower side sets the pace.
// Reset (synchronous, active low) clears the stored sample and loads default registers.
module sample_gap_interpolator
    import sgi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [StepW-1:0]   i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // sample_time, position_value, velocity_value
    input  logic [95:0]        s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_time, out_position, out_velocity
    output logic [95:0]        m_axis_tdata,
    // is_filled
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);

    logic [StepW-1:0] r_step_ticks;
    logic [TolW-1:0]  r_gap_tolerance;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    logic [DataW-1:0] otime;
    logic [DataW-1:0] opos;
    logic [DataW-1:0] ovel;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks    <= StepReset;
            r_gap_tolerance <= TolReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == RegStepTicks) begin
                r_step_ticks <= i_cfg_wdata;
            end else if (i_cfg_idx == RegGapTolerance) begin
                r_gap_tolerance <= i_cfg_wdata[TolW-1:0];
            end
        end
    end

    sgi_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step_ticks    (r_step_ticks),
        .i_gap_tolerance (r_gap_tolerance),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_time          (s_axis_tdata[31:0]),
        .i_pos           (s_axis_tdata[63:32]),
        .i_vel           (s_axis_tdata[95:64]),
        .o_push          (push),
        .o_cmd           (push_cmd),
        .i_full          (full)
    );

    sgi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    sgi_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_time   (otime),
        .o_pos    (opos),
        .o_vel    (ovel),
        .o_filled (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {ovel, opos, otime};

endmodule

@@ design/sgi_div.sv @@
`timescale 1ns / 1ps
module sgi_div
    import sgi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DivNumW-1:0] i_num,
    input  logic [DivDenW-1:0] i_den,
    output logic               o_done,
    output logic [DivNumW-1:0] o_quo
);

    logic [DivNumW-1:0] r_num;
    logic [DivDenW-1:0] r_rem;
    logic [DivDenW-1:0] r_den;
    logic [DivCntW-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DivDenW:0]   trial;
    logic               ge;
    logic [DivDenW:0]   diff;

    // one restoring step: bring in the next numerator bit, try a subtract
    always_comb begin
        trial = {r_rem, r_num[DivNumW-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
                r_num <= {r_num[DivNumW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DivNumW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

@@ design/sgi_queue.sv @@
`timescale 1ns / 1ps
module sgi_queue
    import sgi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ design/sgi_front.sv @@
`timescale 1ns / 1ps
module sgi_front
    import sgi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [StepW-1:0] i_step_ticks,
    input  logic [TolW-1:0]  i_gap_tolerance,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [DataW-1:0] i_time,
    input  logic [DataW-1:0] i_pos,
    input  logic [DataW-1:0] i_vel,
    output logic             o_push,
    output t_cmd             o_cmd,
    input  logic             i_full
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate          r_state;
    t_cmd             r_cmd;
    logic [DataW-1:0] r_prev_time;
    logic [DataW-1:0] r_prev_pos;
    logic [DataW-1:0] r_prev_vel;
    logic             r_have_prev;
    logic             r_div_go;
    logic [DivNumW-1:0] r_div_num;
    logic [DivDenW-1:0] r_div_den;

    logic [StepW-1:0] step;
    logic [DataW-1:0] gap;
    logic [DataW:0]   limit;
    logic             fill;
    logic             accept;
    logic             div_done;
    logic [DivNumW-1:0] div_quo;
    logic [DataW-1:0] ratio;
    logic [DataW-1:0] rm1;

    assign o_ready = r_state == F_IDLE;
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = r_cmd;

    // classify the item against the stored sample
    always_comb begin
        step  = (i_step_ticks == '0) ? StepW'(1) : i_step_ticks;
        gap   = i_time - r_prev_time;
        limit = (DataW + 1)'(step) + (DataW + 1)'(i_gap_tolerance);
        fill  = r_have_prev && (i_time > r_prev_time) && ((DataW + 1)'(gap) > limit);
        ratio = div_quo[DataW-1:0];
        rm1   = ratio - 1'b1;
    end

    sgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_have_prev <= 1'b0;
            r_prev_time <= '0;
            r_prev_pos  <= '0;
            r_prev_vel  <= '0;
            r_div_go    <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_cmd.cur_time <= i_time;
                        r_cmd.cur_pos  <= i_pos;
                        r_cmd.cur_vel  <= i_vel;
                        r_cmd.prev_pos <= r_prev_pos;
                        r_cmd.prev_vel <= r_prev_vel;
                        r_cmd.step     <= step;
                        r_cmd.ratio    <= '0;
                        r_cmd.fill_cnt <= '0;
                        r_prev_time    <= i_time;
                        r_prev_pos     <= i_pos;
                        r_prev_vel     <= i_vel;
                        r_have_prev    <= 1'b1;
                        if (fill) begin
                            // ratio = round(gap / step), halves up
                            r_div_num <= DivNumW'({gap, 1'b0}) + DivNumW'(step);
                            r_div_den <= DivDenW'({step, 1'b0});
                            r_div_go  <= 1'b1;
                            r_state   <= F_DIV;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    if (div_done) begin
                        r_cmd.ratio    <= ratio;
                        r_cmd.fill_cnt <= (rm1 > DataW'(MaxFill)) ? FillW'(MaxFill)
                                                                  : rm1[FillW-1:0];
                        r_state        <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

@@ design/sgi_back.sv @@
`timescale 1ns / 1ps
module sgi_back
    import sgi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [DataW-1:0] o_time,
    output logic [DataW-1:0] o_pos,
    output logic [DataW-1:0] o_vel,
    output logic             o_filled,
    output logic             o_last
);

    typedef enum logic [2:0] {B_IDLE, B_MUL, B_DIV, B_OUT, B_LAST} t_bstate;

    t_bstate            r_state;
    t_cmd               r_cmd;
    logic [FillW-1:0]   r_i;
    logic               r_div_go;
    logic [DivNumW-1:0] r_nump;
    logic [DivNumW-1:0] r_numv;
    logic [DataW-1:0]   r_qp;
    logic [DataW-1:0]   r_qv;
    logic               r_ovalid;
    logic [DataW-1:0]   r_otime;
    logic [DataW-1:0]   r_opos;
    logic [DataW-1:0]   r_ovel;
    logic               r_ofilled;
    logic               r_olast;

    logic [DataW:0]       dp;
    logic [DataW:0]       dv;
    logic [DataW:0]       magp;
    logic [DataW:0]       magv;
    logic [DataW+FillW:0] prodp;
    logic [DataW+FillW:0] prodv;
    logic [DivDenW-1:0]   den;
    logic                 donep;
    logic                 donev;
    logic [DivNumW-1:0]   quop;
    logic [DivNumW-1:0]   quov;
    logic                 slot;
    logic [DataW-1:0]     fpos;
    logic [DataW-1:0]     fvel;
    logic [DataW-1:0]     ftime;

    // signed distance from the current value back to the previous one
    always_comb begin
        dp    = {r_cmd.prev_pos[DataW-1], r_cmd.prev_pos}
              - {r_cmd.cur_pos[DataW-1], r_cmd.cur_pos};
        dv    = {r_cmd.prev_vel[DataW-1], r_cmd.prev_vel}
              - {r_cmd.cur_vel[DataW-1], r_cmd.cur_vel};
        magp  = dp[DataW] ? -dp : dp;
        magv  = dv[DataW] ? -dv : dv;
        prodp = (DataW + FillW + 1)'(magp) * (DataW + FillW + 1)'(r_i);
        prodv = (DataW + FillW + 1)'(magv) * (DataW + FillW + 1)'(r_i);
        den   = DivDenW'({r_cmd.ratio, 1'b0});
        fpos  = dp[DataW] ? r_cmd.cur_pos - r_qp : r_cmd.cur_pos + r_qp;
        fvel  = dv[DataW] ? r_cmd.cur_vel - r_qv : r_cmd.cur_vel + r_qv;
        ftime = r_cmd.cur_time - DataW'(r_cmd.step) * DataW'(r_i);
        slot  = !r_ovalid || i_ready;
    end

    sgi_div u_divp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_nump),
        .i_den   (den),
        .o_done  (donep),
        .o_quo   (quop)
    );

    sgi_div u_divv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_numv),
        .i_den   (den),
        .o_done  (donev),
        .o_quo   (quov)
    );

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_valid  = r_ovalid;
    assign o_time   = r_otime;
    assign o_pos    = r_opos;
    assign o_vel    = r_ovel;
    assign o_filled = r_ofilled;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_cmd;
                        r_i     <= i_cmd.fill_cnt;
                        r_state <= (i_cmd.fill_cnt == '0) ? B_LAST : B_MUL;
                    end
                end
                B_MUL: begin
                    // 2*|d|*i + ratio, rounded division by 2*ratio follows
                    r_nump   <= DivNumW'({prodp, 1'b0}) + DivNumW'(r_cmd.ratio);
                    r_numv   <= DivNumW'({prodv, 1'b0}) + DivNumW'(r_cmd.ratio);
                    r_div_go <= 1'b1;
                    r_state  <= B_DIV;
                end
                B_DIV: begin
                    if (donep && donev) begin
                        r_qp    <= quop[DataW-1:0];
                        r_qv    <= quov[DataW-1:0];
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (slot) begin
                        r_ovalid  <= 1'b1;
                        r_otime   <= ftime;
                        r_opos    <= fpos;
                        r_ovel    <= fvel;
                        r_ofilled <= 1'b1;
                        r_olast   <= 1'b0;
                        r_i       <= r_i - 1'b1;
                        r_state   <= (r_i == FillW'(1)) ? B_LAST : B_MUL;
                    end
                end
                B_LAST: begin
                    if (slot) begin
                        r_ovalid  <= 1'b1;
                        r_otime   <= r_cmd.cur_time;
                        r_opos    <= r_cmd.cur_pos;
                        r_ovel    <= r_cmd.cur_vel;
                        r_ofilled <= 1'b0;
                        r_olast   <= 1'b1;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import sgi_pkg::*;

    // register indexes past the defined registers
    localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;

    typedef struct {
        logic [31:0] t;
        logic [31:0] pos;
        logic [31:0] vel;
        logic        filled;
        logic        last;
    } sample_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [StepW-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [95:0]        s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [95:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    sample_gap_interpolator i_dut (.*);

    // predictor state
    logic [31:0] step_reg, tol_reg;
    logic [31:0] last_t, last_pos, last_vel;
    bit          seen_sample;
    sample_t     expected_q[$];

    int send_idle_pct, recv_idle_pct;
    bit hold_recv;
    int mismatches, results_seen, items_sent, fills_seen, idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // interpolated value: cur + round((prev - cur) * i / r), halves away from zero
    function automatic logic [31:0] line_point(logic signed [31:0] prv,
            logic signed [31:0] cur, longint unsigned i, longint unsigned r);
        longint d;
        longint unsigned mag, q;
        d   = longint'(prv) - longint'(cur);
        mag = (d < 0) ? longint'(-d) : d;
        q   = (mag * i * 2 + r) / (2 * r);
        return (d < 0) ? 32'(longint'(cur) - longint'(q)) : 32'(longint'(cur) + longint'(q));
    endfunction

    // expected output samples for one accepted input
    task automatic predict_fill(logic [31:0] t, logic [31:0] p, logic [31:0] v);
        longint unsigned st, gap, r, m;
        sample_t s;
        if (seen_sample && t > last_t) begin
            st  = (step_reg == 0) ? 1 : step_reg;
            gap = t - last_t;
            if (gap > st + tol_reg) begin
                r = (2 * gap + st) / (2 * st);
                m = (r - 1 > MaxFill) ? MaxFill : r - 1;
                for (longint unsigned i = m; i >= 1; i--) begin
                    s.t      = 32'(longint'(t) - longint'(st * i));
                    s.pos    = line_point(last_pos, p, i, r);
                    s.vel    = line_point(last_vel, v, i, r);
                    s.filled = 1'b1;
                    s.last   = 1'b0;
                    expected_q.push_back(s);
                end
            end
        end
        s = '{t, p, v, 1'b0, 1'b1};
        expected_q.push_back(s);
        last_t = t; last_pos = p; last_vel = v; seen_sample = 1'b1;
    endtask

    task automatic send_sample(logic [31:0] t, logic [31:0] p, logic [31:0] v);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, p, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_fill(t, p, v);
        items_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [StepW-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == RegStepTicks) step_reg = val;
        else if (idx == RegGapTolerance) tol_reg = val & 16'h03FF;
    endtask

    // output checker
    always @(posedge i_clk) begin
        sample_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tuser) fills_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output %h", m_axis_tdata);
            end else begin
                e = expected_q.pop_front();
                if (m_axis_tdata != {e.vel, e.pos, e.t} || m_axis_tuser != e.filled
                        || m_axis_tlast != e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp t=%h p=%h v=%h f=%b l=%b got %h f=%b l=%b",
                                 e.t, e.pos, e.vel, e.filled, e.last, m_axis_tdata,
                                 m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= !hold_recv && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // extremes of the fields, first sample, backwards time, capped gap, zero step
    task automatic test_directed();
        send_sample(32'd1000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'd5000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'd5000, 32'hFFFF_FFFF, 32'h0);
        send_sample(32'd4000, 32'h1234_5678, 32'hFFFF_0000);
        send_sample(32'd6000, 32'h0001_0000, 32'h0);
        send_sample(32'd8100, 32'h0, 32'h0001_0000);
        send_sample(32'd10201, 32'h0002_0000, 32'hFFFE_0000);
        send_sample(32'd15001, 32'h0000_0001, 32'hFFFF_FFFF);
        send_sample(32'd400000, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h0, 32'h0, 32'h0);
        write_reg(RegStepTicks, 16'd0);
        write_reg(RegGapTolerance, 16'd0);
        send_sample(32'd2, 32'h100, 32'h200);
        send_sample(32'd10, 32'h0, 32'h0);
        send_sample(32'd200, 32'hFFFF_FF00, 32'h50);
        write_reg(RegStepTicks, 16'hFFFF);
        write_reg(RegGapTolerance, 16'd1000);
        send_sample(32'd300000, 32'h4000_0000, 32'hC000_0000);
        send_sample(32'hFFFF_0000, 32'hC000_0000, 32'h4000_0000);
        write_reg(RegSpareA, 16'd7);
        write_reg(RegSpareB, 16'd9);
        send_sample(32'hFFFF_FFF0, 32'h0, 32'h0);
    endtask

    // mostly rising timestamps with gaps, some repeats and steps back
    task automatic test_random(int n, logic [15:0] st, logic [9:0] tol);
        logic [31:0] t;
        write_reg(RegStepTicks, st);
        write_reg(RegGapTolerance, 16'(tol));
        t = $urandom();
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9, 0))
                0: t = $urandom();
                1: t = t;
                2: t = t - $urandom_range(3 * st + 5, 1);
                3, 4: t = t + $urandom_range(st + tol, 0);
                default: t = t + $urandom_range(8 * (st + 1) + tol, st);
            endcase
            send_sample(t, $urandom(), $urandom());
        end
    endtask

    // stall the receiver while the sender keeps offering items
    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            test_random(12, 16'd100, 10'd5);
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        hold_recv = 1'b0; idle_cycles = 0;
        step_reg = 2000; tol_reg = 100; seen_sample = 1'b0;
        last_t = 0; last_pos = 0; last_vel = 0;
        send_idle_pct = 27; recv_idle_pct = 82;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(160, 16'd2000, 10'd100);
        test_backpressure();
        send_idle_pct = 82; recv_idle_pct = 27;
        test_random(160, 16'd1, 10'd0);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(150, 16'd37, 10'd1000);
        drain();

        $display("Sent %0d samples, checked %0d outputs (%0d interpolated) over several",
                 items_sent, results_seen, fills_seen);
        $display("step and tolerance settings, with stalls and a long output hold.");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ files.f @@
design/sgi_pkg.sv
design/sgi_div.sv
design/sgi_queue.sv
design/sgi_front.sv
design/sgi_back.sv
design/sample_gap_interpolator.sv
sim/testbench.sv
